@@ hw/rtl/rhs_pkg.sv @@
// Shared types, codes and constants of the roaster heater sequencer.
package rhs_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned SAMPLE_W   = 11;
  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned MAXT_W     = 10;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  // operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_COOL  = 2'd3;

  // run mode codes as shown on the result
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STARTED   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOPPED   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COOLING   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOME_STOP = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HOME_IDLE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_TEMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_SPEED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRUM_SPEED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRUM_SLOW  = 3'd7;

  // reset values of the configuration registers
  localparam logic [TEMP_W-1:0] RST_SETPOINT   = 8'd0;
  localparam logic [MAXT_W-1:0] RST_MAX_TEMP   = 10'd250;
  localparam logic              RST_WINDOW_MOD = 1'b0;
  localparam logic [WIN_W-1:0]  RST_WINDOW_MS  = 16'd1000;
  localparam logic [TEMP_W-1:0] RST_COOL_TEMP  = 8'd50;
  localparam logic [DUTY_W-1:0] RST_FAN_SPEED  = 8'd255;
  localparam logic [DUTY_W-1:0] RST_DRUM_SPEED = 8'd255;
  localparam logic [DUTY_W-1:0] RST_DRUM_SLOW  = 8'd100;

  // sample filtering
  localparam logic [SAMPLE_W-1:0] SAMPLE_ERROR   = 11'd2000;
  localparam logic [SAMPLE_W:0]   TEMP_TOLERANCE = 12'd20;
  localparam logic [TEMP_W-1:0]   TEMP_MAX       = 8'd255;

  typedef enum logic [1:0] {
    HEAT_KEEP,
    HEAT_LOAD,
    HEAT_WINDOW
  } heat_act_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [NOW_W-1:0]    now_ms;
    logic [SAMPLE_W-1:0] sample;
    logic                end_switch;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic [MAXT_W-1:0] max_temp;
    logic              window_mode;
    logic [WIN_W-1:0]  window_ms;
    logic [TEMP_W-1:0] cool_temp;
    logic [DUTY_W-1:0] fan_speed;
    logic [DUTY_W-1:0] drum_speed;
    logic [DUTY_W-1:0] drum_slow_speed;
  } cfg_t;

  // item between the sequencer stage and the heater stage
  typedef struct packed {
    heat_act_t         heat_act;
    logic              heat_bit;
    logic [NOW_W-1:0]  progress;
    logic [DUTY_W-1:0] fan;
    logic [DUTY_W-1:0] drum;
    logic [TEMP_W-1:0] temp;
    logic [MODE_W-1:0] mode;
  } mid_t;

endpackage

@@ hw/rtl/rhs_cfg.sv @@
// Configuration register file of the roaster heater sequencer.
module rhs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [rhs_pkg::CFG_IDX_W-1:0]     index,
  input  logic [rhs_pkg::CFG_DATA_W-1:0]    data,
  output rhs_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint        <= rhs_pkg::RST_SETPOINT;
      cfg.max_temp        <= rhs_pkg::RST_MAX_TEMP;
      cfg.window_mode     <= rhs_pkg::RST_WINDOW_MOD;
      cfg.window_ms       <= rhs_pkg::RST_WINDOW_MS;
      cfg.cool_temp       <= rhs_pkg::RST_COOL_TEMP;
      cfg.fan_speed       <= rhs_pkg::RST_FAN_SPEED;
      cfg.drum_speed      <= rhs_pkg::RST_DRUM_SPEED;
      cfg.drum_slow_speed <= rhs_pkg::RST_DRUM_SLOW;
    end else if (we) begin
      unique case (index)
        rhs_pkg::REG_SETPOINT:   cfg.setpoint        <= data[rhs_pkg::TEMP_W-1:0];
        rhs_pkg::REG_MAX_TEMP:   cfg.max_temp        <= data[rhs_pkg::MAXT_W-1:0];
        rhs_pkg::REG_WINDOW_MOD: cfg.window_mode     <= data[0];
        rhs_pkg::REG_WINDOW_MS:  cfg.window_ms       <= data[rhs_pkg::WIN_W-1:0];
        rhs_pkg::REG_COOL_TEMP:  cfg.cool_temp       <= data[rhs_pkg::TEMP_W-1:0];
        rhs_pkg::REG_FAN_SPEED:  cfg.fan_speed       <= data[rhs_pkg::DUTY_W-1:0];
        rhs_pkg::REG_DRUM_SPEED: cfg.drum_speed      <= data[rhs_pkg::DUTY_W-1:0];
        rhs_pkg::REG_DRUM_SLOW:  cfg.drum_slow_speed <= data[rhs_pkg::DUTY_W-1:0];
      endcase
    end
  end

endmodule

@@ hw/rtl/rhs_core.sv @@
// Sequencer stage: sample filter, run mode, fan and drum, window start.
module rhs_core (
  input  logic            clk,
  input  logic            rst,
  input  rhs_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  rhs_pkg::item_t  item,
  output logic            item_ready,
  output logic            mid_valid,
  output rhs_pkg::mid_t   mid,
  input  logic            mid_ready
);

  typedef enum logic [rhs_pkg::MODE_W-1:0] {
    ST_IDLE      = rhs_pkg::MODE_IDLE,
    ST_STARTED   = rhs_pkg::MODE_STARTED,
    ST_STOPPED   = rhs_pkg::MODE_STOPPED,
    ST_COOLING   = rhs_pkg::MODE_COOLING,
    ST_HOME_STOP = rhs_pkg::MODE_HOME_STOP,
    ST_HOME_IDLE = rhs_pkg::MODE_HOME_IDLE
  } mode_t;

  mode_t                         mode, mode_next;
  logic [rhs_pkg::TEMP_W-1:0]    held_temp, held_temp_next;
  logic [rhs_pkg::NOW_W-1:0]     window_start, window_start_next;
  logic [rhs_pkg::DUTY_W-1:0]    fan, fan_next;
  logic [rhs_pkg::DUTY_W-1:0]    drum, drum_next;
  rhs_pkg::heat_act_t            heat_act;
  logic                          heat_bit;
  logic [rhs_pkg::NOW_W-1:0]     progress;
  logic [rhs_pkg::NOW_W-1:0]     win_len;
  logic                          sample_ok;
  logic                          fire;
  rhs_pkg::mid_t                 mid_next;

  assign item_ready = !mid_valid || mid_ready;
  assign fire       = item_valid && item_ready;
  assign progress   = item.now_ms - window_start;
  assign win_len    = rhs_pkg::NOW_W'(cfg.window_ms);
  assign sample_ok  = (item.sample != '0) && (item.sample != rhs_pkg::SAMPLE_ERROR) &&
                      (({1'b0, item.sample} + rhs_pkg::TEMP_TOLERANCE) >=
                       (rhs_pkg::SAMPLE_W + 1)'(held_temp));

  always_comb begin
    held_temp_next    = held_temp;
    mode_next         = mode;
    window_start_next = window_start;
    fan_next          = fan;
    drum_next         = drum;
    heat_act          = rhs_pkg::HEAT_KEEP;
    heat_bit          = 1'b0;
    unique case (item.op)
      rhs_pkg::OP_TICK: begin
        if (sample_ok) begin
          held_temp_next = (item.sample > rhs_pkg::SAMPLE_W'(rhs_pkg::TEMP_MAX)) ?
                           rhs_pkg::TEMP_MAX : item.sample[rhs_pkg::TEMP_W-1:0];
        end
        unique case (mode)
          ST_STARTED: begin
            if (cfg.window_mode) begin
              heat_act = rhs_pkg::HEAT_WINDOW;
              if (progress > win_len) begin
                window_start_next = window_start + win_len;
              end
            end else begin
              heat_act = rhs_pkg::HEAT_LOAD;
              heat_bit = (held_temp_next <= cfg.setpoint);
            end
          end
          ST_STOPPED: begin
            if (held_temp_next <= cfg.cool_temp) begin
              fan_next = '0;
            end
          end
          ST_COOLING: begin
            if (held_temp_next <= cfg.cool_temp) begin
              heat_act  = rhs_pkg::HEAT_LOAD;
              fan_next  = '0;
              drum_next = cfg.drum_slow_speed;
              mode_next = ST_HOME_IDLE;
              if (!item.end_switch) begin
                drum_next = '0;
                mode_next = ST_IDLE;
              end
            end
          end
          ST_HOME_STOP: begin
            if (!item.end_switch) begin
              drum_next = '0;
              mode_next = ST_STOPPED;
            end
          end
          ST_HOME_IDLE: begin
            if (!item.end_switch) begin
              drum_next = '0;
              mode_next = ST_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      rhs_pkg::OP_START: begin
        fan_next          = cfg.fan_speed;
        drum_next         = cfg.drum_speed;
        mode_next         = ST_STARTED;
        window_start_next = item.now_ms;
      end
      rhs_pkg::OP_STOP: begin
        heat_act  = rhs_pkg::HEAT_LOAD;
        drum_next = cfg.drum_slow_speed;
        mode_next = ST_HOME_STOP;
        if (!item.end_switch) begin
          drum_next = '0;
          mode_next = ST_STOPPED;
        end
      end
      rhs_pkg::OP_COOL: begin
        heat_act  = rhs_pkg::HEAT_LOAD;
        fan_next  = cfg.fan_speed;
        drum_next = cfg.drum_speed;
        mode_next = ST_COOLING;
      end
    endcase

    mid_next.heat_act = heat_act;
    mid_next.heat_bit = heat_bit;
    mid_next.progress = progress;
    mid_next.fan      = fan_next;
    mid_next.drum     = drum_next;
    mid_next.temp     = held_temp_next;
    mid_next.mode     = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ST_IDLE;
      held_temp    <= '0;
      window_start <= '0;
      fan          <= '0;
      drum         <= '0;
      mid_valid    <= 1'b0;
    end else begin
      if (item_ready) begin
        mid_valid <= item_valid;
      end
      if (fire) begin
        mode         <= mode_next;
        held_temp    <= held_temp_next;
        window_start <= window_start_next;
        fan          <= fan_next;
        drum         <= drum_next;
        mid          <= mid_next;
      end
    end
  end

endmodule

@@ hw/rtl/rhs_heater.sv @@
// Heater stage: window duty compare, heater state and the result register.
module rhs_heater (
  input  logic                               clk,
  input  logic                               rst,
  input  rhs_pkg::cfg_t                      cfg,
  input  logic                               mid_valid,
  input  rhs_pkg::mid_t                      mid,
  output logic                               mid_ready,
  output logic                               res_valid,
  output logic [rhs_pkg::OUT_DATA_W-1:0]     res_data,
  input  logic                               res_ready
);

  localparam int unsigned WANT_W = rhs_pkg::TEMP_W + rhs_pkg::WIN_W;
  localparam int unsigned HAVE_W = rhs_pkg::NOW_W + rhs_pkg::MAXT_W;
  localparam int unsigned PAD_W  = rhs_pkg::OUT_DATA_W - 1 - 2 * rhs_pkg::DUTY_W -
                                   rhs_pkg::TEMP_W - rhs_pkg::MODE_W;

  logic [WANT_W-1:0] want;
  logic [HAVE_W-1:0] have;
  logic              win_on;
  logic              heater;
  logic              heater_next;
  logic              load;

  // setpoint * window_ms depends on configuration alone
  always_ff @(posedge clk) begin
    want <= WANT_W'(cfg.setpoint) * WANT_W'(cfg.window_ms);
  end

  assign have      = HAVE_W'(mid.progress) * HAVE_W'(cfg.max_temp);
  assign win_on    = HAVE_W'(want) > have;
  assign mid_ready = !res_valid || res_ready;
  assign load      = mid_valid && mid_ready;

  always_comb begin
    unique case (mid.heat_act)
      rhs_pkg::HEAT_LOAD:   heater_next = mid.heat_bit;
      rhs_pkg::HEAT_WINDOW: heater_next = win_on;
      default:              heater_next = heater;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater    <= 1'b0;
      res_valid <= 1'b0;
    end else if (mid_ready) begin
      res_valid <= mid_valid;
      if (mid_valid) begin
        heater <= heater_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= {{PAD_W{1'b0}}, mid.mode, mid.temp, mid.drum, mid.fan, heater_next};
    end
  end

endmodule

@@ hw/rtl/roaster_heater_sequencer_unit.sv @@
// Top level of the roaster heater, fan and drum sequencer.
//
// Input channel s_axis: one item per tick or event. tuser carries the
// operation (tick with sample, start, stop, cool); tdata carries the
// millisecond time, the thermocouple sample and the drum end switch.
// Output channel m_axis: exactly one result item per input item, in order,
// showing heater drive, fan and drum duty, held temperature and run mode.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while no item is in flight.
//
// Pipeline: input register -> sequencer stage (mode, fan, drum, held
// temperature, window start) -> heater stage (window compare, result reg).
// An accepted item passes the input, sequencer and result registers in turn.
// Throughput: one item per cycle while results are taken; the state loop in
// the sequencer and the 32x10 duty product in the heater are combinational.
// Each stage has its own valid bit, so the block keeps taking items while
// a stalled result waits; with m_axis_tready low it fills all three stages
// and then drops s_axis_tready until the result is taken.
// Reset (rst, synchronous): mode idle, held temperature, window start,
// heater, fan and drum cleared, registers back to defaults, pipeline empty.
module roaster_heater_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] now_ms, [42:32] sample, [43] end_switch, [47:44] zero
  input  logic [rhs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] op
  input  logic [rhs_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] heater_on, [8:1] fan_duty, [16:9] drum_duty, [24:17] temperature,
  // [27:25] mode, [31:28] zero
  output logic [rhs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [rhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned SAMPLE_LO = rhs_pkg::NOW_W;
  localparam int unsigned SAMPLE_HI = SAMPLE_LO + rhs_pkg::SAMPLE_W - 1;
  localparam int unsigned ENDSW_BIT = SAMPLE_HI + 1;

  rhs_pkg::cfg_t  cfg;
  rhs_pkg::item_t item;
  logic           item_valid;
  logic           item_ready;
  rhs_pkg::mid_t  mid;
  logic           mid_valid;
  logic           mid_ready;

  rhs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // input register: holds the item while the sequencer stage is busy
  assign s_axis_tready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.op         <= s_axis_tuser;
      item.now_ms     <= s_axis_tdata[rhs_pkg::NOW_W-1:0];
      item.sample     <= s_axis_tdata[SAMPLE_HI:SAMPLE_LO];
      item.end_switch <= s_axis_tdata[ENDSW_BIT];
    end
  end

  rhs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_ready  (mid_ready)
  );

  rhs_heater u_heater (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready),
    .res_valid (m_axis_tvalid),
    .res_data  (m_axis_tdata),
    .res_ready (m_axis_tready)
  );

endmodule

@@ hw/rtl/rhs_checker.sv @@
// Port-level checks of the roaster heater sequencer, bound to the top level.
module rhs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rhs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  logic [rhs_pkg::MODE_W-1:0] res_mode;
  logic [rhs_pkg::DUTY_W-1:0] res_drum;
  logic                       res_heat;

  assign res_heat = m_axis_tdata[0];
  assign res_drum = m_axis_tdata[16:9];
  assign res_mode = m_axis_tdata[27:25];

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // only the started mode ever drives the heater
  a_heat_started: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_heat |-> res_mode == rhs_pkg::MODE_STARTED)
    else $error("heater on outside started mode");

  // idle and stopped are reached only with the drum at home and parked
  a_drum_parked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res_mode == rhs_pkg::MODE_IDLE || res_mode == rhs_pkg::MODE_STOPPED)
    |-> res_drum == '0)
    else $error("drum running while idle or stopped");

endmodule

bind roaster_heater_sequencer_unit rhs_checker u_rhs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/roaster_heater_sequencer_unit_tb.sv @@
// Self-checking testbench for the roaster heater, fan and drum sequencer.
module roaster_heater_sequencer_unit_tb;
  import rhs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 100;

  // result layout, lowest bit first: heater, fan, drum, temperature, mode
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TEMP_W-1:0] temp;
    logic [DUTY_W-1:0] drum;
    logic [DUTY_W-1:0] fan;
    logic              heater;
  } outputs_t;

  // Predicts the outputs of every accepted item and checks them in order.
  class roast_scoreboard;
    logic [TEMP_W-1:0] setpoint;
    logic [MAXT_W-1:0] max_temp;
    logic              window_mode;
    logic [WIN_W-1:0]  window_ms;
    logic [TEMP_W-1:0] cool_temp;
    logic [DUTY_W-1:0] fan_speed;
    logic [DUTY_W-1:0] drum_speed;
    logic [DUTY_W-1:0] drum_slow;

    logic [MODE_W-1:0] mode;
    logic [TEMP_W-1:0] held;
    logic [NOW_W-1:0]  win_start;
    logic              heater;
    logic [DUTY_W-1:0] fan;
    logic [DUTY_W-1:0] drum;

    outputs_t pending_outputs[$];
    int unsigned fails;

    function new();
      setpoint    = RST_SETPOINT;
      max_temp    = RST_MAX_TEMP;
      window_mode = RST_WINDOW_MOD;
      window_ms   = RST_WINDOW_MS;
      cool_temp   = RST_COOL_TEMP;
      fan_speed   = RST_FAN_SPEED;
      drum_speed  = RST_DRUM_SPEED;
      drum_slow   = RST_DRUM_SLOW;
      mode        = MODE_IDLE;
      held        = '0;
      win_start   = '0;
      heater      = 1'b0;
      fan         = '0;
      drum        = '0;
      fails       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SETPOINT:   setpoint    = val[TEMP_W-1:0];
        REG_MAX_TEMP:   max_temp    = val[MAXT_W-1:0];
        REG_WINDOW_MOD: window_mode = val[0];
        REG_WINDOW_MS:  window_ms   = val[WIN_W-1:0];
        REG_COOL_TEMP:  cool_temp   = val[TEMP_W-1:0];
        REG_FAN_SPEED:  fan_speed   = val[DUTY_W-1:0];
        REG_DRUM_SPEED: drum_speed  = val[DUTY_W-1:0];
        REG_DRUM_SLOW:  drum_slow   = val[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // drum reaches the end switch: homing finishes
    function void settle_home(logic end_switch);
      if (!end_switch) begin
        if (mode == MODE_HOME_STOP) begin
          drum = '0;
          mode = MODE_STOPPED;
        end else if (mode == MODE_HOME_IDLE) begin
          drum = '0;
          mode = MODE_IDLE;
        end
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                            logic [SAMPLE_W-1:0] sample, logic end_switch);
      logic [NOW_W-1:0] progress;
      logic [63:0]      want;
      logic [63:0]      have;
      outputs_t         exp;
      case (op)
        OP_TICK: begin
          // take the sample unless zero, a read error, or too far below the held value
          if (sample != '0 && sample != SAMPLE_ERROR &&
              ({1'b0, sample} + TEMP_TOLERANCE) >= {4'b0, held})
            held = (sample > TEMP_MAX) ? TEMP_MAX : sample[TEMP_W-1:0];
          case (mode)
            MODE_STARTED: begin
              if (window_mode) begin
                progress = now - win_start;
                if (progress > {16'd0, window_ms})
                  win_start = win_start + {16'd0, window_ms};
                want   = {56'd0, setpoint} * {48'd0, window_ms};
                have   = {32'd0, progress} * {54'd0, max_temp};
                heater = (want > have);
              end else begin
                heater = (held <= setpoint);
              end
            end
            MODE_STOPPED: begin
              if (held <= cool_temp)
                fan = '0;
            end
            MODE_COOLING: begin
              if (held <= cool_temp) begin
                heater = 1'b0;
                drum   = drum_slow;
                fan    = '0;
                mode   = MODE_HOME_IDLE;
                settle_home(end_switch);
              end
            end
            MODE_HOME_STOP, MODE_HOME_IDLE: settle_home(end_switch);
            default: ;
          endcase
        end
        OP_START: begin
          fan       = fan_speed;
          drum      = drum_speed;
          mode      = MODE_STARTED;
          win_start = now;
        end
        OP_STOP: begin
          heater = 1'b0;
          drum   = drum_slow;
          mode   = MODE_HOME_STOP;
          settle_home(end_switch);
        end
        default: begin
          heater = 1'b0;
          fan    = fan_speed;
          drum   = drum_speed;
          mode   = MODE_COOLING;
        end
      endcase
      exp.heater = heater;
      exp.fan    = fan;
      exp.drum   = drum;
      exp.temp   = held;
      exp.mode   = mode;
      pending_outputs.push_back(exp);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      outputs_t exp;
      outputs_t got;
      if (pending_outputs.size() == 0) begin
        $error("result item with no expectation waiting: %h", data);
        fails++;
      end else begin
        exp = pending_outputs.pop_front();
        got = data[27:0];
        compare("heater_on", exp.heater, got.heater);
        compare("fan_duty", exp.fan, got.fan);
        compare("drum_duty", exp.drum, got.drum);
        compare("temperature", exp.temp, got.temp);
        compare("mode", exp.mode, got.mode);
        compare("pad", 0, data[31:28]);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  // [31:0] now_ms, [42:32] sample, [43] end_switch, [47:44] zero
  logic [IN_DATA_W-1:0]      s_axis_tdata;
  // [1:0] op
  logic [OP_W-1:0]           s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // [0] heater_on, [8:1] fan_duty, [16:9] drum_duty, [24:17] temperature,
  // [27:25] mode, [31:28] zero
  logic [OUT_DATA_W-1:0]     m_axis_tdata;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  roast_scoreboard sb;

  bit          calm;          // no idling on either side while set
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned items_sent;
  logic [31:0] clock_ms;      // free-running time handed to the block
  int          temp_now;      // simulated bean temperature

  roaster_heater_sequencer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall after every taken result, then check on accept
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        stall_left = draw_gap();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // one item over s_axis; tvalid stays high into the next item when no gap is drawn
  task automatic send_item(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                           logic [SAMPLE_W-1:0] sample, logic end_switch);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, end_switch, sample, now};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(op, now, sample, end_switch);
    items_sent++;
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // phase 1 all registers at minimum but window mode on, phase 2 all bits set,
  // later phases random with junk above each narrower register's width
  task automatic apply_phase_config(int unsigned phase);
    logic [15:0] junk;
    logic [15:0] setp, maxt, wmode, wms, cool, fspd, dspd, dslow;
    junk = 16'($urandom_range(0, 65535));
    if (phase == 1) begin
      {setp, maxt, wms, cool, fspd, dspd, dslow} = '0;
      wmode = 16'd1;
    end else if (phase == 2) begin
      {setp, maxt, wmode, wms, cool, fspd, dspd, dslow} = '1;
    end else begin
      setp  = {junk[15:8], 8'($urandom_range(60, 240))};
      maxt  = {junk[15:10], ($urandom_range(0, 3) == 0) ?
               10'($urandom_range(1, 1023)) : 10'($urandom_range(150, 350))};
      wmode = {junk[15:1], (phase == 3) ? 1'b0 : 1'($urandom_range(0, 1))};
      wms   = 16'($urandom_range(1, 3000));
      cool  = {junk[7:0], 8'($urandom_range(30, 120))};
      fspd  = {junk[11:4], 8'($urandom_range(0, 255))};
      dspd  = {junk[13:6], 8'($urandom_range(0, 255))};
      dslow = {junk[9:2], 8'($urandom_range(0, 255))};
    end
    write_reg(REG_SETPOINT, setp);
    write_reg(REG_MAX_TEMP, maxt);
    write_reg(REG_WINDOW_MOD, wmode);
    write_reg(REG_WINDOW_MS, wms);
    write_reg(REG_COOL_TEMP, cool);
    write_reg(REG_FAN_SPEED, fspd);
    write_reg(REG_DRUM_SPEED, dspd);
    write_reg(REG_DRUM_SLOW, dslow);
    cfg_we <= 1'b0;
  endtask

  // mostly small steps within a window, now and then a wild jump
  task automatic advance_clock();
    if ($urandom_range(0, 19) == 0)
      clock_ms = clock_ms + $urandom();
    else
      clock_ms = clock_ms + $urandom_range(0, sb.window_ms / 2 + 8);
  endtask

  // reading of the simulated temperature, with the odd fault thrown in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    int          low;
    r = $urandom_range(0, 15);
    low = temp_now - int'($urandom_range(25, 60));
    case (r)
      0:       return '0;
      1:       return SAMPLE_ERROR;
      2:       return SAMPLE_W'($urandom_range(0, 2047));
      3:       return SAMPLE_W'((low < 1) ? 1 : low);
      default: return SAMPLE_W'(temp_now);
    endcase
  endfunction

  task automatic send_noise();
    send_item(OP_W'($urandom_range(0, 3)), $urandom(),
              SAMPLE_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick(bit drum_home);
    // a lost sample can leave the held value far above our walk; follow it
    if (temp_now + 20 < int'(sb.held))
      temp_now = int'(sb.held);
    advance_clock();
    send_item(OP_TICK, clock_ms, pick_sample(),
              drum_home ? 1'b0 : 1'($urandom_range(0, 1)));
  endtask

  // start, heat towards setpoint, then stop and/or cool down until homed
  task automatic roast_session();
    int unsigned n;
    int unsigned k;
    int unsigned ending;
    calm = ($urandom_range(0, 3) == 0);
    advance_clock();
    send_item(OP_START, clock_ms, pick_sample(), 1'($urandom_range(0, 1)));
    n = $urandom_range(4, 30);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        send_noise();
      end else begin
        if (temp_now < int'(sb.setpoint) + 5)
          temp_now += $urandom_range(0, 12);
        else
          temp_now += int'($urandom_range(0, 8)) - 5;
        if (temp_now > 320) temp_now = 320;
        if (temp_now < 1) temp_now = 1;
        send_tick(1'b0);
      end
    end
    ending = $urandom_range(0, 3);
    if (ending != 2)
      send_item(OP_STOP, clock_ms, pick_sample(), 1'($urandom_range(0, 3) == 0));
    if (ending >= 2) begin
      if (ending == 3) repeat ($urandom_range(1, 4)) send_tick(1'b0);
      send_item(OP_COOL, clock_ms, pick_sample(), 1'($urandom_range(0, 1)));
    end
    k = 0;
    while (k < 40 && sb.mode != MODE_IDLE &&
           !(sb.mode == MODE_STOPPED && sb.fan == '0)) begin
      temp_now -= $urandom_range(0, 14);
      if (temp_now < 1) temp_now = 1;
      send_tick($urandom_range(0, 3) == 0);
      k++;
    end
  endtask

  initial begin
    int unsigned target;
    sb = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SETPOINT;
    cfg_data      <= '0;
    calm          = 1'b0;
    items_sent    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset configuration: threshold heater, setpoint 0, cool at 50
    send_item(OP_START, 32'd0, 11'd0, 1'b1);
    send_item(OP_TICK, 32'd1, 11'd0, 1'b1);          // zero rejected, heater on at 0
    send_item(OP_TICK, 32'd2, SAMPLE_ERROR, 1'b1);   // read error rejected
    send_item(OP_TICK, 32'd3, 11'd30, 1'b1);         // above setpoint: heater off
    send_item(OP_COOL, 32'd5, 11'd1, 1'b1);
    send_item(OP_TICK, 32'd6, 11'd30, 1'b1);         // cooled, drum not yet home
    send_item(OP_TICK, 32'd7, 11'd30, 1'b1);
    send_item(OP_TICK, 32'd8, 11'd30, 1'b0);         // home: idle
    send_item(OP_STOP, 32'd9, 11'd0, 1'b0);          // homes at once
    send_item(OP_TICK, 32'd10, 11'd45, 1'b1);        // stopped and cool: fan off
    send_item(OP_START, 32'hFFFF_FFF0, 11'd0, 1'b1);
    send_item(OP_TICK, 32'hFFFF_FFFF, 11'd2047, 1'b1); // saturates at 255
    send_item(OP_STOP, 32'd12, 11'd0, 1'b1);
    send_item(OP_TICK, 32'd13, 11'd200, 1'b1);      // drop beyond tolerance
    send_item(OP_COOL, 32'd14, 11'd0, 1'b0);         // homing abandoned
    send_item(OP_TICK, 32'd15, 11'd235, 1'b0);       // just inside tolerance
    send_item(OP_TICK, 32'd16, 11'd1234, 1'b1);
    send_item(OP_TICK, 32'd17, 11'd256, 1'b1);
    send_item(OP_START, 32'd20, 11'd0, 1'b0);
    send_item(OP_TICK, 32'd21, 11'd40, 1'b1);
    send_item(OP_STOP, 32'd22, 11'd0, 1'b1);
    send_item(OP_TICK, 32'd23, SAMPLE_ERROR, 1'b0);  // home, still hot: fan stays
    send_item(OP_COOL, 32'd24, 11'd0, 1'b1);
    send_item(OP_TICK, 32'd25, 11'd1, 1'b0);
    temp_now = int'(sb.held);

    // random phases, each behind a full drain and a register rewrite
    for (int unsigned phase = 1; phase <= PHASES; phase++) begin
      wait_drained();
      apply_phase_config(phase);
      clock_ms = $urandom();
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          calm = 1'b0;
          repeat ($urandom_range(5, 10)) send_noise();
        end else begin
          roast_session();
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.fails == 0 && sb.pending_outputs.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rhs_pkg.sv
hw/rtl/rhs_cfg.sv
hw/rtl/rhs_core.sv
hw/rtl/rhs_heater.sv
hw/rtl/roaster_heater_sequencer_unit.sv
hw/rtl/rhs_checker.sv
verif/roaster_heater_sequencer_unit_tb.sv
